// ----- design/bmst_pkg.sv -----
// Package for the bounded member set table: sizes, request and status codes,
// and the command struct broadcast along the cell row.
// No dependencies.
package bmst_pkg;

  // Sizing: one slot is kept back, so the table holds LIST_SLOTS - 1 ids
  localparam int unsigned LIST_SLOTS = 64;
  localparam int unsigned CAPACITY   = LIST_SLOTS - 1;
  localparam int unsigned CNT_W      = $clog2(LIST_SLOTS);
  localparam int unsigned ID_W       = 31;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned STATUS_W   = 3;

  typedef enum logic [1:0] {
    MODE_CHECK = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_DEL   = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ABSENT  = 3'd1,
    ST_PRESENT = 3'd2,
    ST_FULL    = 3'd3,
    ST_INDEX   = 3'd4
  } status_e;

  // Command broadcast to every cell in the row
  typedef struct packed {
    logic            del;
    logic [ID_W-1:0] id;
  } cell_cmd_t;

endpackage

// ----- design/bmst_cell.sv -----
// One slot of the member table: holds an id, compares it against the request
// and takes its right-hand neighbour's value when a delete closes a gap.
// Depends on bmst_pkg.
module bmst_cell import bmst_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  cell_cmd_t       cmd_i,
  input  logic            active_i,
  input  logic            wr_i,
  input  logic            seen_i,
  input  logic [ID_W-1:0] next_i,
  output logic            seen_o,
  output logic [ID_W-1:0] entry_o
);

  logic [ID_W-1:0] entry_q;
  logic            match;

  // Compare only slots that hold a live entry
  assign match   = active_i && (entry_q == cmd_i.id);
  // Propagate "match at or left of here" to the next cell
  assign seen_o  = seen_i || match;
  assign entry_o = entry_q;

  // Append writes the new id; delete shifts down from the matched slot onward
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wr_i) begin
        entry_q <= cmd_i.id;
      end else if (cmd_i.del && seen_o) begin
        entry_q <= next_i;
      end
    end
  end

endmodule

// ----- design/bmst_chain.sv -----
// Row of CAPACITY table cells with the match chain running left to right and
// the compaction data running right to left.
// Depends on bmst_pkg and bmst_cell.
module bmst_chain import bmst_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  cell_cmd_t        cmd_i,
  input  logic             add_i,
  input  logic [CNT_W-1:0] count_i,
  output logic             hit_o,
  output logic [ID_W-1:0]  entries_o [CAPACITY]
);

  logic [CAPACITY:0] seen;

  assign seen[0] = 1'b0;

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic            active;
    logic            wr;
    logic [ID_W-1:0] next;

    assign active = CNT_W'(j) < count_i;
    assign wr     = add_i && (count_i == CNT_W'(j));

    // Last cell feeds back its own value; it falls out of range on delete
    if (j < CAPACITY - 1) begin : g_mid
      assign next = entries_o[j+1];
    end else begin : g_last
      assign next = entries_o[j];
    end

    bmst_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (en_i),
      .cmd_i    (cmd_i),
      .active_i (active),
      .wr_i     (wr),
      .seen_i   (seen[j]),
      .next_i   (next),
      .seen_o   (seen[j+1]),
      .entry_o  (entries_o[j])
    );
  end

  assign hit_o = seen[CAPACITY];

endmodule

// ----- design/bounded_member_set_table_unit.sv -----
// Bounded member set table: an ordered list of up to 63 distinct 31-bit ids.
// Each request (check, add, delete, read by index) yields exactly one result
// carrying a status, the id read (zero outside read mode or on an index
// error) and the entry count after the request. A request is first captured;
// then every cell of the row compares its id in parallel and the row appends
// or compacts. A new request is not accepted until the previous one has
// executed; a result waiting on out_ready_i holds back only the execute cycle
// of the following request. Entries need no clearing after reset.
module bounded_member_set_table_unit import bmst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [ID_W-1:0]     member_id_i,
  input  logic [POS_W-1:0]    position_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [ID_W-1:0]     entry_value_o,
  output logic [CNT_W-1:0]    entry_count_o
);

  logic                busy_q;
  mode_e               mode_q;
  logic [ID_W-1:0]     id_q;
  logic [POS_W-1:0]    pos_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                out_valid_q;
  status_e             status_q, status_d;
  logic [ID_W-1:0]     value_q, value_d;
  logic [CNT_W-1:0]    out_cnt_q;

  logic                accept;
  logic                exec;
  logic                hit;
  logic                full;
  logic                add_ok;
  logic                del_ok;
  logic                pos_ok;
  cell_cmd_t           cmd;
  logic [ID_W-1:0]     entries [CAPACITY];

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  // Execute once the output register is free or being drained
  assign exec       = busy_q && (!out_valid_q || out_ready_i);

  // Capture the request transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (exec) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_e'(mode_i);
      id_q   <= member_id_i;
      pos_q  <= position_i;
    end
  end

  // Cell row
  assign cmd.del = (mode_q == MODE_DEL);
  assign cmd.id  = id_q;

  bmst_chain u_chain (
    .clk_i     (clk_i),
    .en_i      (exec),
    .cmd_i     (cmd),
    .add_i     (add_ok),
    .count_i   (count_q),
    .hit_o     (hit),
    .entries_o (entries)
  );

  // Decide the outcome
  assign full   = (count_q == CNT_W'(CAPACITY));
  assign add_ok = (mode_q == MODE_ADD) && !hit && !full;
  assign del_ok = (mode_q == MODE_DEL) && hit;
  assign pos_ok = (pos_q < count_q);

  always_comb begin
    status_d = ST_OK;
    value_d  = '0;
    count_d  = count_q;
    case (mode_q)
      MODE_CHECK: status_d = hit ? ST_OK : ST_ABSENT;
      MODE_ADD: begin
        if (hit) begin
          status_d = ST_PRESENT;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      MODE_DEL: begin
        if (del_ok) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          status_d = ST_ABSENT;
        end
      end
      MODE_READ: begin
        if (pos_ok) begin
          value_d = entries[pos_q];
        end else begin
          status_d = ST_INDEX;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  // Hold the count and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q  <= status_d;
      value_q   <= value_d;
      out_cnt_q <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_value_o = value_q;
  assign entry_count_o = out_cnt_q;

  // Count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Count moves only in an execute cycle
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec |=> $stable(count_q))
    else $error("entry count changed outside execute");

  // Every execute leaves a result in the output register
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> out_valid_q && (out_cnt_q == count_q))
    else $error("execute produced no result");

  // No accept while a request is still pending
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && !in_ready_o)
    else $error("request accepted while busy");

endmodule

// ----- tb/sv/bounded_member_set_table_unit_tb.sv -----
// Testbench for bounded_member_set_table_unit: directed and random requests,
// each reply checked against a mirror of the id list kept in a small class.
// Depends on bmst_pkg and the unit itself.
`timescale 1ns / 1ps

module bounded_member_set_table_unit_tb;
  import bmst_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    status_e         status;
    logic [ID_W-1:0] value;
    logic [CNT_W-1:0] count;
  } reply_t;

  // Mirror of the ordered id list; predicts one reply per accepted request
  class member_list_mirror;
    logic [ID_W-1:0] ids[$];
    reply_t          pending_replies[$];
    int unsigned     mismatches;

    function int find_id(logic [ID_W-1:0] id);
      foreach (ids[i]) begin
        if (ids[i] == id) return i;
      end
      return -1;
    endfunction

    // Apply an accepted transaction and queue the reply it must produce
    function void log_request(mode_e mode, logic [ID_W-1:0] id, logic [POS_W-1:0] pos);
      reply_t r;
      int     slot;
      r.status = ST_OK;
      r.value  = '0;
      slot     = find_id(id);
      case (mode)
        MODE_CHECK: begin
          if (slot < 0) r.status = ST_ABSENT;
        end
        MODE_ADD: begin
          if (slot >= 0) r.status = ST_PRESENT;
          else if (ids.size() >= CAPACITY) r.status = ST_FULL;
          else ids.push_back(id);
        end
        MODE_DEL: begin
          // deleting from the queue closes the gap just as the row compacts
          if (slot < 0) r.status = ST_ABSENT;
          else ids.delete(slot);
        end
        default: begin
          if (int'(pos) >= ids.size()) r.status = ST_INDEX;
          else r.value = ids[pos];
        end
      endcase
      r.count = CNT_W'(ids.size());
      pending_replies.push_back(r);
    endfunction

    // Compare one accepted reply with the oldest prediction
    function void check_reply(logic [STATUS_W-1:0] status, logic [ID_W-1:0] value,
                              logic [CNT_W-1:0] count);
      reply_t exp;
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding: status %0d value %0h count %0d",
               status, value, count);
        mismatches++;
        return;
      end
      exp = pending_replies.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status);
        mismatches++;
      end
      if (value !== exp.value) begin
        $error("entry_value: expected %0h, got %0h", exp.value, value);
        mismatches++;
      end
      if (count !== exp.count) begin
        $error("entry_count: expected %0d, got %0d", exp.count, count);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [1:0]          mode_i        = MODE_CHECK;
  logic [ID_W-1:0]     member_id_i   = '0;
  logic [POS_W-1:0]    position_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [ID_W-1:0]     entry_value_o;
  logic [CNT_W-1:0]    entry_count_o;

  member_list_mirror mirror = new();
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_idle_pct = 0;
  int unsigned       cycle_count = 0;
  bit                growing = 1'b1;

  bounded_member_set_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .member_id_i   (member_id_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .entry_count_o (entry_count_o)
  );

  always #1 clk_i = ~clk_i;

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: stall at random, sample replies mid-cycle where they are stable
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      mirror.check_reply(status_o, entry_value_o, entry_count_o);
  end

  // Offer one request; called at a rising edge, returns at the accepting edge
  task automatic send_request(mode_e mode, logic [ID_W-1:0] id, logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    member_id_i <= id;
    position_i  <= pos;
    @(negedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    mirror.log_request(mode, id, pos);
    @(posedge clk_i);
  endtask

  // Mostly meaningful traffic: grow towards full, then shrink towards empty
  task automatic send_random_request();
    int unsigned     n;
    int unsigned     roll;
    mode_e           mode;
    logic [ID_W-1:0] id;
    logic [POS_W-1:0] pos;
    n = mirror.ids.size();
    if (n == 0) growing = 1'b1;
    else if (n == CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
    else if ($urandom_range(0, 199) == 0) growing = !growing;
    roll = $urandom_range(0, 99);
    if (roll < 55) mode = growing ? MODE_ADD : MODE_DEL;
    else if (roll < 70) mode = MODE_CHECK;
    else if (roll < 82) mode = growing ? MODE_DEL : MODE_ADD;
    else mode = MODE_READ;
    roll = $urandom_range(0, 99);
    if (roll < 50 && n > 0) id = mirror.ids[$urandom_range(0, n - 1)];
    else if (roll < 85) id = ID_W'($urandom_range(0, 95));
    else id = ID_W'($urandom());
    if ($urandom_range(0, 99) < 70) pos = POS_W'($urandom_range(0, n));
    else pos = POS_W'($urandom_range(0, 63));
    send_request(mode, id, pos);
  endtask

  // Drop valid and hold off until every reply is in, then let the unit settle
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (mirror.pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random_phase(int unsigned items, int unsigned tx_pct,
                                  int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (items) send_random_request();
    drain_replies();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, field extremes, duplicates, index bounds, compaction
    send_request(MODE_CHECK, '0, '0);
    send_request(MODE_DEL, ID_W'(5), '0);
    send_request(MODE_READ, '0, '0);
    send_request(MODE_ADD, '0, '1);
    send_request(MODE_ADD, '1, '0);
    send_request(MODE_ADD, 31'h2AAA_AAAA, 6'h2A);
    send_request(MODE_ADD, 31'h5555_5555, 6'h15);
    send_request(MODE_ADD, '0, '0);
    send_request(MODE_CHECK, '1, '0);
    send_request(MODE_READ, '0, POS_W'(0));
    send_request(MODE_READ, '0, POS_W'(3));
    send_request(MODE_READ, '0, POS_W'(4));
    send_request(MODE_READ, '1, '1);
    send_request(MODE_DEL, '1, '0);
    send_request(MODE_READ, '0, POS_W'(1));
    send_request(MODE_READ, '0, POS_W'(3));
    send_request(MODE_DEL, '0, '0);
    send_request(MODE_DEL, 31'h5555_5555, '0);
    send_request(MODE_CHECK, '0, '0);
    send_request(MODE_READ, '0, POS_W'(0));
    drain_replies();

    // Random: slow receiver, then slow sender, then back to back
    run_random_phase(270, 27, 55);
    run_random_phase(270, 55, 27);
    run_random_phase(260, 0, 0);

    if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
